// ===== sv/tqpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqpr_pkg
// Shared constants, codes and controller/datapath types of the 2Q page pool.
// ----------------------------------------------------------------------------
package tqpr_pkg;

  localparam int FRAMES    = 16;
  localparam int FRAME_W   = $clog2(FRAMES);
  localparam int CNT_W     = FRAME_W + 1;
  localparam int PAGE_BITS = 16;
  localparam int PIN_BITS  = 8;
  localparam int LIMIT_W   = 5;
  localparam int STATUS_W  = 3;
  localparam int MODE_W    = 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
  localparam logic [PIN_BITS-1:0] PIN_MAX    = {PIN_BITS{1'b1}};
  localparam logic MODE_UNFIX                = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT          = 3'd0,
    ST_LOADED       = 3'd1,
    ST_EVICTED      = 3'd2,
    ST_FULL         = 3'd3,
    ST_UNFIXED      = 3'd4,
    ST_NOT_RESIDENT = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_SCAN_FIFO,
    S_SCAN_LRU,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic clr_idx;
    logic inc_idx;
    logic look;
    logic scan_lru;
    logic take_fifo;
    logic take_lru;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_frame;
    logic fifo_end;
    logic lru_end;
    logic unpinned;
    logic done_now;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/tqpr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqpr_req_if / tqpr_rsp_if
// Valid/ready channels for requests and results of the 2Q page pool.
// ----------------------------------------------------------------------------
interface tqpr_req_if;
  import tqpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [PAGE_BITS-1:0] page_number;
  logic                 mark_dirty;
  modport source (output valid, mode, page_number, mark_dirty, input ready);
  modport sink   (input valid, mode, page_number, mark_dirty, output ready);
endinterface

interface tqpr_rsp_if;
  import tqpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [FRAME_W-1:0]   frame_index;
  logic [PAGE_BITS-1:0] evicted_page;
  logic                 flush_needed;
  logic [PIN_BITS-1:0]  pins_now;
  modport source (output valid, status, frame_index, evicted_page, flush_needed, pins_now,
                  input ready);
  modport sink   (input valid, status, frame_index, evicted_page, flush_needed, pins_now,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/tqpr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqpr_ctrl
// Sequencer: lookup pass, eviction scans over both queues, commit.
// ----------------------------------------------------------------------------
module tqpr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tqpr_pkg::sts_t sts,
  output tqpr_pkg::cmd_t cmd
);
  import tqpr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.look = 1'b1;
        if (sts.last_frame) begin
          cmd.clr_idx = 1'b1;
          state_next  = S_DECIDE;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_DECIDE: begin
        if (sts.done_now) begin
          state_next = S_COMMIT;
        end else begin
          cmd.clr_idx = 1'b1;
          state_next  = S_SCAN_FIFO;
        end
      end
      S_SCAN_FIFO: begin
        if (sts.fifo_end) begin
          cmd.clr_idx = 1'b1;
          state_next  = S_SCAN_LRU;
        end else if (sts.unpinned) begin
          cmd.take_fifo = 1'b1;
          state_next    = S_COMMIT;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_SCAN_LRU: begin
        cmd.scan_lru = 1'b1;
        if (sts.lru_end) begin
          state_next = S_COMMIT;
        end else if (sts.unpinned) begin
          cmd.take_lru = 1'b1;
          state_next   = S_COMMIT;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tqpr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqpr_datapath
// Frame table, FIFO and LRU queues, scan registers and result register.
// ----------------------------------------------------------------------------
module tqpr_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  tqpr_pkg::cmd_t                 cmd,
  output tqpr_pkg::sts_t                 sts,
  input  logic [tqpr_pkg::MODE_W-1:0]    in_mode,
  input  logic [tqpr_pkg::PAGE_BITS-1:0] in_page,
  input  logic                           in_dirty,
  input  logic                           cfg_wr_en,
  input  logic [tqpr_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [tqpr_pkg::STATUS_W-1:0]  out_status,
  output logic [tqpr_pkg::FRAME_W-1:0]   out_frame,
  output logic [tqpr_pkg::PAGE_BITS-1:0] out_evp,
  output logic                           out_flush,
  output logic [tqpr_pkg::PIN_BITS-1:0]  out_pins
);
  import tqpr_pkg::*;

  logic                 req_mode;
  logic [PAGE_BITS-1:0] req_page;
  logic                 req_dirty;
  logic [CNT_W-1:0]     idx;
  logic                 hit;
  logic [FRAME_W-1:0]   hit_frame;
  logic [PIN_BITS-1:0]  hit_pins;
  logic                 free_ok;
  logic [FRAME_W-1:0]   free_frame;
  logic                 ev_ok;
  logic                 ev_lru;
  logic [FRAME_W-1:0]   ev_frame;
  logic [FRAME_W-1:0]   ev_pos;
  logic [PAGE_BITS-1:0] ev_page;
  logic                 ev_dirty;
  logic [LIMIT_W-1:0]   limit_reg;

  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [FRAMES-1:0]    frame_valid;
  logic [FRAMES-1:0]    frame_dirty;
  logic [PIN_BITS-1:0]  frame_pins [FRAMES];
  logic [FRAME_W-1:0]   fifo_q [FRAMES];
  logic [FRAME_W-1:0]   lru_q [FRAMES];
  logic [CNT_W-1:0]     fifo_len;
  logic [CNT_W-1:0]     lru_len;

  logic [FRAME_W-1:0]   rd_addr;
  logic [PIN_BITS-1:0]  pins_rd;
  logic [PAGE_BITS-1:0] page_rd;
  logic                 valid_rd;
  logic                 dirty_rd;
  logic                 match_now;
  logic [CNT_W-1:0]     total;
  logic [CNT_W-1:0]     lim;
  logic                 need_evict;
  logic                 is_fix;
  logic                 load_ok;
  logic [FRAME_W-1:0]   slot;
  logic [PIN_BITS-1:0]  pins_inc;
  logic [PIN_BITS-1:0]  pins_dec;
  logic [FRAMES-1:0]    mf, ml, rm_f, rm_l;
  logic                 f_dec, l_dec;
  logic [CNT_W-1:0]     fifo_len_rm, lru_len_rm;
  logic [FRAME_W-1:0]   fifo_next [FRAMES];
  logic [FRAME_W-1:0]   lru_next [FRAMES];
  logic [CNT_W-1:0]     fifo_len_next, lru_len_next;
  status_t              res_status;
  logic [FRAME_W-1:0]   res_frame;
  logic [PIN_BITS-1:0]  res_pins;

  assign rd_addr = cmd.look     ? idx[FRAME_W-1:0] :
                   cmd.scan_lru ? lru_q[idx[FRAME_W-1:0]] : fifo_q[idx[FRAME_W-1:0]];
  assign pins_rd   = frame_pins[rd_addr];
  assign page_rd   = frame_page[rd_addr];
  assign valid_rd  = frame_valid[rd_addr];
  assign dirty_rd  = frame_dirty[rd_addr];
  assign match_now = valid_rd && (page_rd == req_page);

  assign total = fifo_len + lru_len;
  assign lim   = (limit_reg == '0) ? CNT_W'(1) :
                 (int'(limit_reg) > FRAMES) ? CNT_W'(FRAMES) : CNT_W'(limit_reg);
  assign need_evict = (total >= lim);
  assign is_fix     = (req_mode != MODE_UNFIX);

  assign sts.last_frame = (idx[FRAME_W-1:0] == FRAME_W'(FRAMES - 1));
  assign sts.fifo_end   = (idx >= fifo_len);
  assign sts.lru_end    = (idx >= lru_len);
  assign sts.unpinned   = (pins_rd == '0);
  assign sts.done_now   = !is_fix || hit || !need_evict;
  assign sts.out_free   = !out_valid || out_ready;

  assign pins_inc = (hit_pins == PIN_MAX) ? hit_pins : hit_pins + PIN_BITS'(1);
  assign pins_dec = (hit_pins == '0) ? hit_pins : hit_pins - PIN_BITS'(1);
  assign load_ok  = is_fix && !hit && (ev_ok || !need_evict);
  assign slot     = !ev_ok ? free_frame :
                    (free_ok && (free_frame < ev_frame)) ? free_frame : ev_frame;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      mf[i] = (CNT_W'(i) < fifo_len) && (fifo_q[i] == hit_frame);
      ml[i] = (CNT_W'(i) < lru_len) && (lru_q[i] == hit_frame);
    end
    for (int i = 0; i < FRAMES; i++) begin
      if (hit) begin
        rm_f[i] = (i == 0) ? mf[i] : (mf[i] || rm_f[i-1]);
        rm_l[i] = (i == 0) ? ml[i] : (ml[i] || rm_l[i-1]);
      end else begin
        rm_f[i] = ev_ok && !ev_lru && (FRAME_W'(i) >= ev_pos);
        rm_l[i] = ev_ok && ev_lru && (FRAME_W'(i) >= ev_pos);
      end
    end
    f_dec = hit ? (|mf) : (ev_ok && !ev_lru);
    l_dec = hit ? (|ml) : (ev_ok && ev_lru);
    fifo_len_rm = fifo_len - CNT_W'(f_dec);
    lru_len_rm  = lru_len - CNT_W'(l_dec);
    for (int i = 0; i < FRAMES; i++) begin
      fifo_next[i] = fifo_q[i];
      lru_next[i]  = lru_q[i];
      if (i < FRAMES - 1) begin
        if (rm_f[i]) begin
          fifo_next[i] = fifo_q[i+1];
        end
        if (rm_l[i]) begin
          lru_next[i] = lru_q[i+1];
        end
      end
    end
    fifo_len_next = fifo_len_rm;
    lru_len_next  = lru_len_rm;
    if (hit) begin
      lru_next[lru_len_rm[FRAME_W-1:0]] = hit_frame;
      lru_len_next = lru_len_rm + CNT_W'(1);
    end else if (load_ok) begin
      fifo_next[fifo_len_rm[FRAME_W-1:0]] = slot;
      fifo_len_next = fifo_len_rm + CNT_W'(1);
    end
  end

  always_comb begin
    res_status = ST_FULL;
    res_frame  = '0;
    res_pins   = '0;
    if (!is_fix) begin
      res_status = hit ? ST_UNFIXED : ST_NOT_RESIDENT;
      if (hit) begin
        res_frame = hit_frame;
        res_pins  = pins_dec;
      end
    end else if (hit) begin
      res_status = ST_HIT;
      res_frame  = hit_frame;
      res_pins   = pins_inc;
    end else if (load_ok) begin
      res_status = ev_ok ? ST_EVICTED : ST_LOADED;
      res_frame  = slot;
      res_pins   = PIN_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      hit         <= 1'b0;
      free_ok     <= 1'b0;
      ev_ok       <= 1'b0;
      limit_reg   <= LIMIT_RESET;
      frame_valid <= '0;
      frame_dirty <= '0;
      fifo_len    <= '0;
      lru_len     <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_pins[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        limit_reg <= cfg_wr_data;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.capture) begin
        idx     <= '0;
        hit     <= 1'b0;
        free_ok <= 1'b0;
        ev_ok   <= 1'b0;
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end
      if (cmd.inc_idx) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.look) begin
        if (match_now) begin
          hit <= 1'b1;
        end
        if (!valid_rd && !free_ok) begin
          free_ok <= 1'b1;
        end
      end
      if (cmd.take_fifo || cmd.take_lru) begin
        ev_ok <= 1'b1;
      end
      if (cmd.commit) begin
        if (is_fix) begin
          fifo_len <= fifo_len_next;
          lru_len  <= lru_len_next;
        end
        if (!is_fix && hit) begin
          frame_pins[hit_frame] <= pins_dec;
          if (req_dirty) begin
            frame_dirty[hit_frame] <= 1'b1;
          end
        end else if (is_fix && hit) begin
          frame_pins[hit_frame] <= pins_inc;
        end else if (load_ok) begin
          if (ev_ok && (slot != ev_frame)) begin
            frame_valid[ev_frame] <= 1'b0;
            frame_dirty[ev_frame] <= 1'b0;
          end
          frame_valid[slot] <= 1'b1;
          frame_dirty[slot] <= 1'b0;
          frame_pins[slot]  <= PIN_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode  <= in_mode[0];
      req_page  <= in_page;
      req_dirty <= in_dirty;
    end
    if (cmd.look) begin
      if (match_now) begin
        hit_frame <= rd_addr;
        hit_pins  <= pins_rd;
      end
      if (!valid_rd && !free_ok) begin
        free_frame <= rd_addr;
      end
    end
    if (cmd.take_fifo || cmd.take_lru) begin
      ev_lru   <= cmd.take_lru;
      ev_frame <= rd_addr;
      ev_pos   <= idx[FRAME_W-1:0];
      ev_page  <= page_rd;
      ev_dirty <= dirty_rd;
    end
    if (cmd.commit) begin
      if (is_fix) begin
        for (int i = 0; i < FRAMES; i++) begin
          fifo_q[i] <= fifo_next[i];
          lru_q[i]  <= lru_next[i];
        end
      end
      if (load_ok) begin
        frame_page[slot] <= req_page;
      end
      out_status <= res_status;
      out_frame  <= res_frame;
      out_pins   <= res_pins;
      out_evp    <= (load_ok && ev_ok) ? ev_page : '0;
      out_flush  <= load_ok && ev_ok && ev_dirty;
    end
  end

endmodule
`default_nettype wire

// ===== sv/two_queue_page_replacement_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_queue_page_replacement_core
// Page buffer pool with 2Q replacement: fix/unfix requests, one result each.
//
//   Channel  Dir  Handshake    Payload
//   req      in   valid/ready  mode, page_number, mark_dirty
//   rsp      out  valid/ready  status, frame_index, evicted_page, flush_needed,
//                              pins_now
//   cfg      in   cfg_wr_en    cfg_wr_data (frames_in_use)
//
// One request at a time. Hit, unfix or free load: a lookup pass over every frame
// of the frame table, then the result. A miss on a full pool also scans the FIFO
// queue for an unpinned page and, if none is found there, the LRU queue.
// Synchronous reset empties the pool; the result register holds under stall
// and the next request is accepted while a result waits.
// ----------------------------------------------------------------------------
module two_queue_page_replacement_core (
  input  logic                         clk,
  input  logic                         rst,
  tqpr_req_if.sink                     req,
  tqpr_rsp_if.source                   rsp,
  input  logic                         cfg_wr_en,
  input  logic [tqpr_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import tqpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tqpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tqpr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (req.mode),
    .in_page     (req.page_number),
    .in_dirty    (req.mark_dirty),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_status  (rsp.status),
    .out_frame   (rsp.frame_index),
    .out_evp     (rsp.evicted_page),
    .out_flush   (rsp.flush_needed),
    .out_pins    (rsp.pins_now)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while busy");

  a_no_evict_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_EVICTED) |-> (rsp.evicted_page == '0) && !rsp.flush_needed)
    else $error("eviction fields set without eviction");

  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && ((rsp.status == ST_FULL) || (rsp.status == ST_NOT_RESIDENT))
    |-> (rsp.frame_index == '0) && (rsp.pins_now == '0))
    else $error("frame or pins set on full or non-resident result");

  a_fix_pinned: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && ((rsp.status == ST_HIT) || (rsp.status == ST_LOADED) ||
                  (rsp.status == ST_EVICTED)) |-> (rsp.pins_now != '0))
    else $error("fixed page reports zero pins");
`endif

endmodule
`default_nettype wire
